### hw/rtl/grid_line_of_sight_check_assert.svh
// Assertion macros for the grid line-of-sight checker files.
// No dependencies; include once per compilation unit that asserts.
`ifndef GRID_LINE_OF_SIGHT_CHECK_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLOS_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("grid line-of-sight check assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GLOS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("grid line-of-sight check assertion failed");

`endif

### hw/rtl/glos_pkg.sv
// Shared types, constants and helpers for the grid line-of-sight checker.
// No dependencies.
package glos_pkg;

  localparam int unsigned CoordW = 8;
  localparam int unsigned CfgW   = 9;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgGridWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGridHeight = 2'd1;

  localparam logic [CfgW-1:0] CfgDimReset = 9'd256;

  // Occupancy values at or above this mark a cell blocked
  localparam logic signed [7:0] BlockLevel = 8'sd100;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic              is_query;
    logic              range_err;
    logic              blk;
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic [CoordW-1:0] ex;
    logic [CoordW-1:0] ey;
  } cmd_t;

  // Grid size in use
  typedef struct packed {
    logic [CfgW-1:0] width;
    logic [CfgW-1:0] height;
  } dims_t;

  // True when a coordinate lies below both the register limit and the store size
  function automatic logic in_range(input logic [CfgW-1:0] c, input logic [CfgW-1:0] lim,
                                    input int unsigned max_dim);
    return (c < lim) && (32'(c) < max_dim);
  endfunction

endpackage

### hw/rtl/glos_front.sv
// Front end: configuration registers, input handshake and item classification.
// Depends on glos_pkg.
module glos_front #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [glos_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [glos_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               mode_i,
  input  logic [glos_pkg::CoordW-1:0]        start_x_i,
  input  logic [glos_pkg::CoordW-1:0]        start_y_i,
  input  logic [glos_pkg::CoordW-1:0]        end_x_i,
  input  logic [glos_pkg::CoordW-1:0]        end_y_i,
  input  logic signed [7:0]                  cell_value_i,
  input  logic                               q_full_i,
  input  logic                               clearing_i,
  output logic                               push_o,
  output glos_pkg::cmd_t                     cmd_o,
  output glos_pkg::dims_t                    dims_o
);

  logic [glos_pkg::CfgW-1:0] width_q, width_d;
  logic [glos_pkg::CfgW-1:0] height_q, height_d;
  logic start_ok, end_ok;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        glos_pkg::CfgGridWidth:  width_d  = cfg_data_i;
        glos_pkg::CfgGridHeight: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= glos_pkg::CfgDimReset;
      height_q <= glos_pkg::CfgDimReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign dims_o.width  = width_q;
  assign dims_o.height = height_q;

  // Hold off items while the queue is full or the map is being cleared
  assign in_stall_o = q_full_i || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o;

  // Classify: range check the start point, and the end point too for a query; threshold the written value
  assign start_ok = glos_pkg::in_range({1'b0, start_x_i}, width_q, MAX_DIM) &&
                    glos_pkg::in_range({1'b0, start_y_i}, height_q, MAX_DIM);
  assign end_ok   = glos_pkg::in_range({1'b0, end_x_i}, width_q, MAX_DIM) &&
                    glos_pkg::in_range({1'b0, end_y_i}, height_q, MAX_DIM);

  assign cmd_o.is_query  = mode_i;
  assign cmd_o.range_err = mode_i ? !(start_ok && end_ok) : !start_ok;
  assign cmd_o.blk       = (cell_value_i >= glos_pkg::BlockLevel);
  assign cmd_o.sx        = start_x_i;
  assign cmd_o.sy        = start_y_i;
  assign cmd_o.ex        = end_x_i;
  assign cmd_o.ey        = end_y_i;

endmodule

### hw/rtl/glos_queue.sv
// Two-entry command queue between the front and the back end.
// Depends on glos_pkg.
module glos_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  glos_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output glos_pkg::cmd_t data_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  glos_pkg::cmd_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth-1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth-1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + (PtrW+1)'(1);
      2'b01:   count_d = count_q - (PtrW+1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/glos_back.sv
// Back end: occupancy map memory, clearing pass, ray walker and result register.
// Depends on glos_pkg.
module glos_back #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  glos_pkg::cmd_t  q_data_i,
  output logic            q_pop_o,
  input  glos_pkg::dims_t dims_i,
  output logic            clearing_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            blocked_o,
  output logic            status_o
);

  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(Depth);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_SIDE  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic signed [9:0] x_q, x_d, y_q, y_d;
  logic              xs_q, xs_d, ys_q, ys_d;
  logic [7:0]        dx_q, dx_d, dy_q, dy_d;
  logic signed [11:0] err_q, err_d;
  logic [8:0]        steps_q, steps_d;
  logic [7:0]        ex_q, ex_d, ey_q, ey_d;
  logic              hit_q, hit_d;
  logic              rd_vld_q;
  logic              out_valid_q, out_valid_d;
  logic              blocked_q, blocked_d;
  logic              status_q, status_d;

  logic              map_mem [Depth];
  logic              mem_q;
  logic              we, wdata;
  logic [AW-1:0]     waddr, raddr;
  logic              rd_req, rd_en;
  logic signed [9:0] rd_x, rd_y;
  logic signed [9:0] x_step, y_step;
  logic signed [11:0] dx2, dy2;
  logic [7:0]        new_dx, new_dy;

  function automatic logic [AW-1:0] cell_addr(input logic [8:0] cx, input logic [8:0] cy);
    return AW'(32'(cy) * 32'(MAX_DIM) + 32'(cx));
  endfunction

  function automatic logic cell_ok(input logic signed [9:0] cx, input logic signed [9:0] cy,
                                   input glos_pkg::dims_t d);
    return !cx[9] && !cy[9] &&
           glos_pkg::in_range(cx[8:0], d.width, MAX_DIM) &&
           glos_pkg::in_range(cy[8:0], d.height, MAX_DIM);
  endfunction

  assign x_step = xs_q ? x_q + 10'sd1 : x_q - 10'sd1;
  assign y_step = ys_q ? y_q + 10'sd1 : y_q - 10'sd1;
  assign dx2    = $signed({3'b000, dx_q, 1'b0});
  assign dy2    = $signed({3'b000, dy_q, 1'b0});
  assign new_dx = (q_data_i.ex > q_data_i.sx) ? q_data_i.ex - q_data_i.sx
                                              : q_data_i.sx - q_data_i.ex;
  assign new_dy = (q_data_i.ey > q_data_i.sy) ? q_data_i.ey - q_data_i.sy
                                              : q_data_i.sy - q_data_i.ey;

  assign clearing_o  = (state_q == S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign blocked_o   = blocked_q;
  assign status_o    = status_q;

  // Sequence clearing, writes and the walk, one map access per cycle
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    x_d         = x_q;
    y_d         = y_q;
    xs_d        = xs_q;
    ys_d        = ys_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    err_d       = err_q;
    steps_d     = steps_q;
    ex_d        = ex_q;
    ey_d        = ey_q;
    hit_d       = hit_q | (rd_vld_q & mem_q);
    out_valid_d = out_valid_q && out_stall_i;
    blocked_d   = blocked_q;
    status_d    = status_q;
    q_pop_o     = 1'b0;
    we          = 1'b0;
    waddr       = clr_q;
    wdata       = 1'b0;
    rd_req      = 1'b0;
    rd_x        = x_q;
    rd_y        = y_q;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(Depth-1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        hit_d = 1'b0;
        if (q_valid_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          if (!q_data_i.is_query) begin
            // Store the cell, or report an out-of-range write
            if (!q_data_i.range_err) begin
              we    = 1'b1;
              waddr = cell_addr({1'b0, q_data_i.sx}, {1'b0, q_data_i.sy});
              wdata = q_data_i.blk;
            end
            out_valid_d = 1'b1;
            blocked_d   = q_data_i.blk && !q_data_i.range_err;
            status_d    = q_data_i.range_err;
          end else if (q_data_i.range_err) begin
            out_valid_d = 1'b1;
            blocked_d   = 1'b1;
            status_d    = 1'b1;
          end else begin
            // Set up the walker
            x_d     = $signed({2'b00, q_data_i.sx});
            y_d     = $signed({2'b00, q_data_i.sy});
            xs_d    = q_data_i.ex > q_data_i.sx;
            ys_d    = q_data_i.ey > q_data_i.sy;
            dx_d    = new_dx;
            dy_d    = new_dy;
            err_d   = $signed({4'b0000, new_dx}) - $signed({4'b0000, new_dy});
            steps_d = {1'b0, new_dx} + {1'b0, new_dy};
            ex_d    = q_data_i.ex;
            ey_d    = q_data_i.ey;
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        rd_req = 1'b1;
        if (steps_q != '0) begin
          if (err_q > 12'sd0) begin
            x_d     = x_step;
            err_d   = err_q - dy2;
            steps_d = steps_q - 9'd1;
          end else if (err_q == 12'sd0) begin
            state_d = S_SIDE;
          end else begin
            y_d     = y_step;
            err_d   = err_q + dx2;
            steps_d = steps_q - 9'd1;
          end
        end else begin
          // Visit the end cell last
          rd_x    = $signed({2'b00, ex_q});
          rd_y    = $signed({2'b00, ey_q});
          state_d = S_DONE;
        end
      end
      S_SIDE: begin
        // Exact corner: visit the cell one column over, then step the row
        rd_req  = 1'b1;
        rd_x    = x_step;
        y_d     = y_step;
        err_d   = err_q + dx2;
        steps_d = steps_q - 9'd1;
        state_d = S_WALK;
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        blocked_d   = hit_d;
        status_d    = 1'b0;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rd_en = rd_req && cell_ok(rd_x, rd_y, dims_i);
  assign raddr = rd_en ? cell_addr(rd_x[8:0], rd_y[8:0]) : '0;

  // Map memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      map_mem[waddr] <= wdata;
    end
    mem_q <= map_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_vld_q    <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  // Walker and result payload
  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    xs_q      <= xs_d;
    ys_q      <= ys_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    err_q     <= err_d;
    steps_q   <= steps_d;
    ex_q      <= ex_d;
    ey_q      <= ey_d;
    hit_q     <= hit_d;
    blocked_q <= blocked_d;
    status_q  <= status_d;
  end

endmodule

### hw/rtl/grid_line_of_sight_check.sv
// Grid line-of-sight checker, top level. A write item stores one map cell and returns a
// result; a query item walks the map from start to end, reading one cell per cycle and
// also the side cell at each exact corner, and returns whether any cell was blocked.
// Items are handled one at a time: the next item starts the cycle after a result is
// taken, and two items queue ahead. After reset the map is cleared one cell per cycle,
// with in_stall_o high; register writes are taken throughout.
module grid_line_of_sight_check #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [glos_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [glos_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [glos_pkg::CoordW-1:0]  start_x_i,
  input  logic [glos_pkg::CoordW-1:0]  start_y_i,
  input  logic [glos_pkg::CoordW-1:0]  end_x_i,
  input  logic [glos_pkg::CoordW-1:0]  end_y_i,
  input  logic signed [7:0]            cell_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         blocked_o,
  output logic                         status_o
);

  glos_pkg::cmd_t  push_cmd, pop_cmd;
  glos_pkg::dims_t dims;
  logic            push, q_full, q_valid, q_pop, clearing;

  glos_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .cell_value_i (cell_value_i),
    .q_full_i     (q_full),
    .clearing_i   (clearing),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .dims_o       (dims)
  );

  glos_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (pop_cmd)
  );

  glos_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_cmd),
    .q_pop_o     (q_pop),
    .dims_i      (dims),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .blocked_o   (blocked_o),
    .status_o    (status_o)
  );

endmodule

### hw/rtl/glos_checker.sv
// Port-level checker for the grid line-of-sight checker, bound to the top level.
// Depends on grid_line_of_sight_check_assert.svh.
`include "grid_line_of_sight_check_assert.svh"

module glos_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_valid_i,
  input logic cfg_ready_o,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic blocked_o,
  input logic status_o
);

  logic [2:0] pend_q, pend_d;
  logic       in_acc, out_acc, out_wait;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign out_wait = out_valid_o && out_stall_i;

  // Track items accepted but not yet delivered
  always_comb begin
    pend_d = pend_q;
    case ({in_acc, out_acc})
      2'b10:   pend_d = pend_q + 3'd1;
      2'b01:   pend_d = pend_q - 3'd1;
      default: pend_d = pend_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Hold a stalled result, deliver only what was taken, stall when full, configure only idle
  `GLOS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable({blocked_o, status_o}))
  `GLOS_ASSERT_NOW(a_out_pending, clk_i, rst_ni, out_valid_o, pend_q != 3'd0)
  `GLOS_ASSERT_NOW(a_full_stall, clk_i, rst_ni, pend_q == 3'd3, in_stall_o)
  `GLOS_ASSERT_NOW(a_cfg_idle, clk_i, rst_ni, cfg_valid_i && cfg_ready_o, pend_q == 3'd0)

endmodule

bind grid_line_of_sight_check glos_checker u_glos_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .blocked_o   (blocked_o),
  .status_o    (status_o)
);

### tb/tb.sv
// Self-checking testbench for grid_line_of_sight_check: occupancy writes and
// line-of-sight queries under several grid sizes, checked against an internal
// ray tracer. Depends on glos_pkg and the grid_line_of_sight_check RTL.
`timescale 1ns / 100ps

module tb;

  localparam int GRID_DIM      = 256;
  localparam int GRID_CELLS    = GRID_DIM * GRID_DIM;
  localparam int IDLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int MAX_REPORTS   = 10;

  localparam bit ModeWrite   = 1'b0;
  localparam bit ModeQuery   = 1'b1;
  localparam bit StatusOk    = 1'b0;
  localparam bit StatusRange = 1'b1;

  // One expected result plus the item that caused it
  typedef struct {
    bit   mode;
    int   sx, sy, ex, ey;
    logic blocked;
    logic status;
  } sight_result_t;

  // Occupancy predictor and result checker
  class sight_scoreboard;
    bit                        cell_map[GRID_CELLS];
    logic [glos_pkg::CfgW-1:0] width_reg  = glos_pkg::CfgDimReset;
    logic [glos_pkg::CfgW-1:0] height_reg = glos_pkg::CfgDimReset;
    sight_result_t             pending_results[$];
    int errors, checked, n_writes, n_queries, n_hits, n_range;

    function int eff_dim(logic [glos_pkg::CfgW-1:0] r);
      return (r > GRID_DIM) ? GRID_DIM : int'(r);
    endfunction

    function bit on_grid(int x, int y);
      return x >= 0 && y >= 0 && x < eff_dim(width_reg) && y < eff_dim(height_reg);
    endfunction

    function bit cell_hit(int x, int y);
      if (!on_grid(x, y)) return 1'b0;
      return cell_map[y * GRID_DIM + x];
    endfunction

    // Walk the ray with integer error stepping; ties also probe the side cell
    function bit trace_ray(int sx, int sy, int ex, int ey);
      int dx, dy, xs, ys, err, steps, x, y;
      bit hit;
      dx    = (ex > sx) ? ex - sx : sx - ex;
      dy    = (ey > sy) ? ey - sy : sy - ey;
      xs    = (ex > sx) ? 1 : -1;
      ys    = (ey > sy) ? 1 : -1;
      err   = dx - dy;
      steps = dx + dy;
      x     = sx;
      y     = sy;
      hit   = 1'b0;
      for (; steps > 0; steps--) begin
        if (cell_hit(x, y)) hit = 1'b1;
        if (err > 0) begin
          x   += xs;
          err -= 2 * dy;
        end else begin
          if (err == 0 && cell_hit(x + xs, y)) hit = 1'b1;
          y   += ys;
          err += 2 * dx;
        end
      end
      if (cell_hit(ex, ey)) hit = 1'b1;
      return hit;
    endfunction

    function void set_reg(logic [glos_pkg::CfgIdxW-1:0] idx, logic [glos_pkg::CfgW-1:0] data);
      if (idx == glos_pkg::CfgGridWidth) width_reg = data;
      else if (idx == glos_pkg::CfgGridHeight) height_reg = data;
    endfunction

    // Update the map and queue the result for one accepted item
    function void note_item(bit mode, int sx, int sy, int ex, int ey, logic [7:0] val);
      sight_result_t r;
      bit b;
      r.mode = mode;
      r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
      if (mode == ModeWrite) begin
        n_writes++;
        if (!on_grid(sx, sy)) begin
          r.blocked = 1'b0;
          r.status  = StatusRange;
          n_range++;
        end else begin
          b = ($signed(val) >= glos_pkg::BlockLevel);
          cell_map[sy * GRID_DIM + sx] = b;
          r.blocked = b;
          r.status  = StatusOk;
        end
      end else begin
        n_queries++;
        if (!on_grid(sx, sy) || !on_grid(ex, ey)) begin
          r.blocked = 1'b1;
          r.status  = StatusRange;
          n_range++;
        end else begin
          r.blocked = trace_ray(sx, sy, ex, ey);
          r.status  = StatusOk;
          if (r.blocked) n_hits++;
        end
      end
      pending_results = {pending_results, r};
    endfunction

    function void check_result(logic blocked, logic status);
      sight_result_t r;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: result with nothing pending: blocked=%b status=%b", blocked, status);
        return;
      end
      r = pending_results.pop_front();
      checked++;
      if (blocked !== r.blocked || status !== r.status) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: mode=%0d (%0d,%0d)->(%0d,%0d) exp blocked=%b status=%b, got %b %b",
                   r.mode, r.sx, r.sy, r.ex, r.ey, r.blocked, r.status, blocked, status);
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [glos_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [glos_pkg::CfgW-1:0]     cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          mode_i;
  logic [glos_pkg::CoordW-1:0]   start_x_i;
  logic [glos_pkg::CoordW-1:0]   start_y_i;
  logic [glos_pkg::CoordW-1:0]   end_x_i;
  logic [glos_pkg::CoordW-1:0]   end_y_i;
  logic signed [7:0]             cell_value_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic                          blocked_o;
  logic                          status_o;

  sight_scoreboard sb;
  bit quiet;
  int stall_left;
  int idle_cycles;
  int n_settings;

  grid_line_of_sight_check dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .cell_value_i(cell_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .blocked_o   (blocked_o),
    .status_o    (status_o)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side at random
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(blocked_o, status_o);
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input bit mode, input int sx, input int sy, input int ex,
                           input int ey, input int val);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i       <= mode;
    start_x_i    <= sx[glos_pkg::CoordW-1:0];
    start_y_i    <= sy[glos_pkg::CoordW-1:0];
    end_x_i      <= ex[glos_pkg::CoordW-1:0];
    end_y_i      <= ey[glos_pkg::CoordW-1:0];
    cell_value_i <= val[7:0];
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(mode, sx & 8'hFF, sy & 8'hFF, ex & 8'hFF, ey & 8'hFF, val[7:0]);
  endtask

  // Hold the sender until every pending result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [glos_pkg::CfgIdxW-1:0] idx,
                           input logic [glos_pkg::CfgW-1:0] data);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_dims(input int w, input int h);
    drain_results();
    write_reg(glos_pkg::CfgGridWidth, w[glos_pkg::CfgW-1:0]);
    write_reg(glos_pkg::CfgGridHeight, h[glos_pkg::CfgW-1:0]);
    n_settings++;
  endtask

  // Coordinate mostly inside the grid, sometimes just past it or anywhere
  function automatic int pick_coord(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 8) return $urandom_range(0, 255);
    if (r < 12 && lim < GRID_DIM) return lim;
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic int near_coord(int c);
    int v;
    v = c + $urandom_range(0, 24) - 12;
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  function automatic int pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(100, 127);
    if (r < 36) return 100;
    if (r < 42) return 99;
    return $urandom_range(0, 255);
  endfunction

  task automatic random_phase(input int w, input int h, input int count);
    int ew, eh, sx, sy, ex, ey;
    set_dims(w, h);
    quiet = ($urandom_range(0, 3) == 0);
    ew = sb.eff_dim(w[glos_pkg::CfgW-1:0]);
    eh = sb.eff_dim(h[glos_pkg::CfgW-1:0]);
    for (int k = 0; k < count; k++) begin
      if (k == count / 2 || $urandom_range(0, 59) == 0) drain_results();
      sx = pick_coord(ew);
      sy = pick_coord(eh);
      if ($urandom_range(0, 99) < 35) begin
        send_item(ModeWrite, sx, sy, $urandom_range(0, 255), $urandom_range(0, 255),
                  pick_value());
      end else begin
        if ($urandom_range(0, 99) < 80) begin
          ex = near_coord(sx);
          ey = near_coord(sy);
        end else begin
          ex = pick_coord(ew);
          ey = pick_coord(eh);
        end
        send_item(ModeQuery, sx, sy, ex, ey, $urandom_range(0, 255));
      end
    end
    quiet = 1'b0;
  endtask

  int phase_w[8] = '{16, 256, 1, 40, 300, 0, 7, 256};
  int phase_h[8] = '{16, 256, 1, 25, 511, 20, 200, 3};
  int phase_n[8] = '{140, 90, 25, 140, 70, 15, 90, 80};

  initial begin
    sb          = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = glos_pkg::CfgGridWidth;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    mode_i      = ModeWrite;
    start_x_i   = '0;
    start_y_i   = '0;
    end_x_i     = '0;
    end_y_i     = '0;
    cell_value_i = '0;
    out_stall_i = 1'b0;
    quiet       = 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
    n_settings  = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Full grid: value thresholds, corners, long diagonals, zero-length rays
    set_dims(256, 256);
    send_item(ModeWrite, 0, 0, 255, 255, 127);
    send_item(ModeQuery, 0, 0, 0, 0, 0);
    send_item(ModeWrite, 0, 0, 170, 85, 99);
    send_item(ModeWrite, 255, 255, 85, 170, 100);
    send_item(ModeQuery, 0, 0, 255, 255, 255);
    send_item(ModeWrite, 255, 255, 0, 0, -128);
    send_item(ModeQuery, 255, 0, 0, 255, 127);
    send_item(ModeWrite, 3, 3, 0, 0, 127);
    send_item(ModeQuery, 2, 2, 4, 4, 0);
    send_item(ModeQuery, 4, 2, 2, 4, 0);
    send_item(ModeWrite, 170, 85, 255, 0, -1);
    send_item(ModeQuery, 160, 85, 180, 85, 0);
    send_item(ModeWrite, 85, 170, 0, 255, 100);
    send_item(ModeQuery, 85, 255, 85, 0, 0);
    send_item(ModeQuery, 255, 255, 255, 255, 0);

    // Small grid: out-of-range writes and queries, rays along the edge
    set_dims(10, 8);
    send_item(ModeWrite, 10, 0, 0, 0, 127);
    send_item(ModeWrite, 0, 8, 0, 0, 127);
    send_item(ModeQuery, 0, 0, 10, 0, 0);
    send_item(ModeQuery, 11, 3, 2, 2, 0);
    send_item(ModeWrite, 9, 7, 0, 0, 120);
    send_item(ModeQuery, 9, 0, 8, 1, 0);
    send_item(ModeQuery, 9, 0, 9, 7, 0);
    send_item(ModeQuery, 0, 7, 9, 0, 0);

    // Zero-sized grid rejects every coordinate
    set_dims(0, 5);
    send_item(ModeWrite, 0, 0, 0, 0, 127);
    send_item(ModeQuery, 0, 0, 0, 0, 0);

    for (int p = 0; p < 8; p++) random_phase(phase_w[p], phase_h[p], phase_n[p]);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending_results.size() != 0) sb.errors++;

    $display("Ran %0d writes and %0d queries over %0d grid sizes: %0d rays blocked, %0d range errors",
             sb.n_writes, sb.n_queries, n_settings, sb.n_hits, sb.n_range);
    $display("Checked %0d results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
